[rtl/core/bsb_pkg.sv]
// Shared constants and types for the bounding sphere block.
`timescale 1ns / 1ps

package bsb_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int COORD_BITS   = 24;

  localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int RSQ_W  = 50;
  localparam int RAD_W  = 25;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int STEP_W = $clog2(RAD_W + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [RSQ_W-1:0]             rsq_t;
  typedef logic [RAD_W-1:0]             rad_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam rsq_t   RSQ_MAX   = {RSQ_W{1'b1}};
  localparam cnt_t   CNT_FULL  = CNT_W'(MAX_VERTICES);

endpackage

[rtl/core/bsb_if.sv]
// Valid/ready channel interfaces for vertex requests and sphere results.
`timescale 1ns / 1ps

interface bsb_vtx_if import bsb_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t vx;
  coord_t vy;
  coord_t vz;
  logic   last_vertex;

  modport source (output valid, vx, vy, vz, last_vertex, input ready);
  modport sink   (input valid, vx, vy, vz, last_vertex, output ready);
endinterface

interface bsb_sph_if import bsb_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t center_x;
  coord_t center_y;
  coord_t center_z;
  rsq_t   radius_sq;
  rad_t   radius;
  cnt_t   vertex_count;
  logic   overflow;

  modport source (output valid, center_x, center_y, center_z, radius_sq, radius,
                  vertex_count, overflow, input ready);
  modport sink   (input valid, center_x, center_y, center_z, radius_sq, radius,
                  vertex_count, overflow, output ready);
endinterface

[rtl/core/bounding_sphere_from_box_top.sv]
// Bounding sphere from the axis-aligned box of a vertex stream.
//
// vtx_i carries one vertex request per cycle while the block is loading
// (x, y, z in signed Q15.8 and a last flag). Vertices go into a 1024-entry
// vertex memory while the per-axis minimum and maximum are tracked. A vertex
// that finds the memory full is dropped and sets the overflow flag.
// After the last vertex the block stops taking requests: a center state
// forms the box midpoint, then a scan reads back every stored vertex through
// the single memory read port, pipelined through difference, square, sum and
// max stages, then a restoring square root runs one result bit per cycle.
// Loading runs at one vertex per cycle while the block is in its load state.
// The result sits in an output register until taken; a stalled receiver
// holds it, and the next mesh may load meanwhile. A new result waits
// at the end of the square root until the output register is free.
// Reset empties the mesh; memory contents need no clearing.
`timescale 1ns / 1ps

module bounding_sphere_from_box_top import bsb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  bsb_vtx_if.sink          vtx_i,
  bsb_sph_if.source        sph_o
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CENTER,
    ST_SCAN,
    ST_SQRT
  } state_e;

  state_e state_q;
  cnt_t   count_q;
  logic   ovf_q;
  coord_t min_q [3];
  coord_t max_q [3];
  coord_t ctr_q [3];
  cnt_t   rd_addr_q;
  logic   v1_q, v2_q, v3_q, v4_q;
  rsq_t   best_q;
  logic [STEP_W-1:0] step_q;
  logic   out_valid_q;

  logic [3*COORD_BITS-1:0] mem [MAX_VERTICES];
  logic [3*COORD_BITS-1:0] ram_q;
  logic [DIFF_W-1:0]       ad_q [3];
  logic [SQ_W-1:0]         sq_q [3];
  rsq_t                    sum_q;
  rsq_t                    rad_q;
  logic [RAD_W+1:0]        rem_q;
  rad_t                    root_q;

  coord_t out_ctr_q [3];
  rsq_t   out_rsq_q;
  rad_t   out_rad_q;
  cnt_t   out_cnt_q;
  logic   out_ovf_q;

  coord_t vin [3];
  logic   vtx_acc;
  logic   store_en;
  logic   rd_en;
  logic   scan_done;
  logic   publish;
  logic [DIFF_W-1:0] ad_d [3];
  logic [SUM_W-1:0]  sum_d;
  logic [RAD_W+1:0]  rem_sh;
  logic [RAD_W+1:0]  trial;

  assign vin[0] = vtx_i.vx;
  assign vin[1] = vtx_i.vy;
  assign vin[2] = vtx_i.vz;

  assign vtx_i.ready = (state_q == ST_LOAD);
  assign vtx_acc     = vtx_i.valid && vtx_i.ready;
  assign store_en    = vtx_acc && (count_q != CNT_FULL);
  assign rd_en       = (state_q == ST_SCAN) && (rd_addr_q != count_q);
  assign scan_done   = (state_q == ST_SCAN) && (rd_addr_q == count_q) &&
                       !v1_q && !v2_q && !v3_q && !v4_q;
  assign publish     = (state_q == ST_SQRT) && (step_q == '0) &&
                       (!out_valid_q || sph_o.ready);

  // Distance datapath: absolute difference to the center per axis.
  always_comb begin
    logic signed [DIFF_W-1:0] d;
    coord_t                   v;
    for (int j = 0; j < 3; j++) begin
      v = ram_q[j*COORD_BITS +: COORD_BITS];
      d = {v[COORD_BITS-1], v} - {ctr_q[j][COORD_BITS-1], ctr_q[j]};
      ad_d[j] = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    end
  end

  assign sum_d = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);

  // One restoring square root step: bring down two radicand bits.
  assign rem_sh = {rem_q[RAD_W-1:0], rad_q[RSQ_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  // Vertex memory: one write port for loading, one registered read port.
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem[count_q[ADDR_W-1:0]] <= {vin[2], vin[1], vin[0]};
    end
    if (rd_en) begin
      ram_q <= mem[rd_addr_q[ADDR_W-1:0]];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      ad_q[j] <= ad_d[j];
      sq_q[j] <= ad_q[j] * ad_q[j];
    end
    sum_q <= (sum_d > SUM_W'(RSQ_MAX)) ? RSQ_MAX : sum_d[RSQ_W-1:0];

    if (state_q == ST_CENTER) begin
      for (int j = 0; j < 3; j++) begin
        ctr_q[j] <= coord_t'((COORD_BITS+1)'({min_q[j][COORD_BITS-1], min_q[j]} +
                                             {max_q[j][COORD_BITS-1], max_q[j]}) >> 1);
      end
    end

    if (scan_done) begin
      rad_q  <= best_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == ST_SQRT && step_q != '0) begin
      rad_q <= {rad_q[RSQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RAD_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RAD_W-2:0], 1'b0};
      end
    end

    if (publish) begin
      for (int j = 0; j < 3; j++) begin
        out_ctr_q[j] <= ctr_q[j];
      end
      out_rsq_q <= best_q;
      out_rad_q <= root_q;
      out_cnt_q <= count_q;
      out_ovf_q <= ovf_q;
    end
  end

  // Control: mesh state, scan pipeline valids, sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        min_q[j] <= COORD_MAX;
        max_q[j] <= COORD_MIN;
      end
      rd_addr_q   <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      best_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;

      if (publish) begin
        out_valid_q <= 1'b1;
      end else if (sph_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_LOAD: begin
          if (vtx_acc) begin
            if (store_en) begin
              count_q <= count_q + 1'b1;
              for (int j = 0; j < 3; j++) begin
                if (vin[j] < min_q[j]) min_q[j] <= vin[j];
                if (vin[j] > max_q[j]) max_q[j] <= vin[j];
              end
            end else begin
              ovf_q <= 1'b1;
            end
            if (vtx_i.last_vertex) begin
              state_q <= ST_CENTER;
            end
          end
        end
        ST_CENTER: begin
          rd_addr_q <= '0;
          best_q    <= '0;
          state_q   <= ST_SCAN;
        end
        ST_SCAN: begin
          if (rd_en) begin
            rd_addr_q <= rd_addr_q + 1'b1;
          end
          if (v4_q && (sum_q > best_q)) begin
            best_q <= sum_q;
          end
          if (scan_done) begin
            step_q  <= STEP_W'(RAD_W);
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (step_q != '0) begin
            step_q <= step_q - 1'b1;
          end else if (publish) begin
            // Start a new mesh.
            count_q <= '0;
            ovf_q   <= 1'b0;
            for (int j = 0; j < 3; j++) begin
              min_q[j] <= COORD_MAX;
              max_q[j] <= COORD_MIN;
            end
            state_q <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign sph_o.valid        = out_valid_q;
  assign sph_o.center_x     = out_ctr_q[0];
  assign sph_o.center_y     = out_ctr_q[1];
  assign sph_o.center_z     = out_ctr_q[2];
  assign sph_o.radius_sq    = out_rsq_q;
  assign sph_o.radius       = out_rad_q;
  assign sph_o.vertex_count = out_cnt_q;
  assign sph_o.overflow     = out_ovf_q;

endmodule
